### rtl/ufpd_pkg.sv
package ufpd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 12;
  localparam int unsigned MAX_LEN = 2048;
  // count saturates at the smaller of MAX_LEN and the field's top value
  localparam int unsigned LEN_CAP = (MAX_LEN < 4095) ? MAX_LEN : 4095;
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned CMD_BYTES = 3;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'd0;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
  localparam logic [BYTE_W-1:0] CH_PCT   = 8'd37;
  localparam logic [BYTE_W-1:0] CH_AMP   = 8'd38;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'd43;
  localparam logic [BYTE_W-1:0] CH_LT    = 8'd60;
  localparam logic [BYTE_W-1:0] CH_GT    = 8'd62;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;
  } in_item_t;

  typedef struct packed {
    logic              out_kind;
    logic [BYTE_W-1:0] out_byte;
    logic [LEN_W-1:0]  out_length;
  } out_item_t;

  // one item's worth of work: up to three data bytes, then an optional end
  typedef struct packed {
    logic [1:0]                        n_data;
    logic [CMD_BYTES-1:0][BYTE_W-1:0] data_bytes;
    logic                              has_end;
  } cmd_t;

  function automatic logic hex_ok(input logic [BYTE_W-1:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [3:0] hex_val(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] v;
    if (c >= "0" && c <= "9") begin
      v = c - 8'd48;
    end else if (c >= "A" && c <= "F") begin
      v = c - 8'd55;
    end else begin
      v = c - 8'd87;
    end
    return v[3:0];
  endfunction

endpackage

### rtl/ufpd_front.sv
module ufpd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ufpd_pkg::in_item_t in_item_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output ufpd_pkg::cmd_t    q_cmd_o
);
  import ufpd_pkg::*;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_PCT    = 2'd1;
  localparam logic [1:0] MODE_PCT1   = 2'd2;
  localparam logic [1:0] MODE_ENDED  = 2'd3;

  logic [1:0]        mode_q, mode_d;
  logic [BYTE_W-1:0] held_q, held_d;
  logic              accept;
  cmd_t              cmd;
  logic [BYTE_W-1:0] b;
  logic              term;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign b          = in_item_i.in_byte;
  assign term       = (b == CH_AMP) || (b == CH_LT) || (b == CH_GT) ||
                      (b == CH_LF) || (b == CH_NUL);

  always_comb begin
    mode_d = mode_q;
    held_d = held_q;
    cmd    = '0;
    unique case (mode_q)
      MODE_NORMAL: begin
        if (b == CH_PLUS) begin
          cmd.data_bytes[cmd.n_data] = CH_SPACE;
          cmd.n_data = cmd.n_data + 2'd1;
        end else if (b == CH_PCT) begin
          mode_d = MODE_PCT;
        end else if (term) begin
          cmd.has_end = 1'b1;
          mode_d      = MODE_ENDED;
        end else begin
          cmd.data_bytes[cmd.n_data] = b;
          cmd.n_data = cmd.n_data + 2'd1;
        end
      end
      MODE_PCT: begin
        if (b == CH_NUL) begin
          cmd.data_bytes[cmd.n_data] = CH_PCT;
          cmd.n_data  = cmd.n_data + 2'd1;
          cmd.has_end = 1'b1;
          mode_d      = MODE_ENDED;
        end else begin
          held_d = b;
          mode_d = MODE_PCT1;
        end
      end
      MODE_PCT1: begin
        mode_d = MODE_NORMAL;
        held_d = '0;
        if (hex_ok(held_q) && hex_ok(b)) begin
          cmd.data_bytes[cmd.n_data] = {hex_val(held_q), hex_val(b)};
          cmd.n_data = cmd.n_data + 2'd1;
        end else begin
          // bad escape goes out raw
          cmd.data_bytes[cmd.n_data] = CH_PCT;
          cmd.n_data = cmd.n_data + 2'd1;
          cmd.data_bytes[cmd.n_data] = held_q;
          cmd.n_data = cmd.n_data + 2'd1;
          if (b == CH_NUL) begin
            cmd.has_end = 1'b1;
            mode_d      = MODE_ENDED;
          end else begin
            cmd.data_bytes[cmd.n_data] = b;
            cmd.n_data = cmd.n_data + 2'd1;
          end
        end
      end
      default: begin
      end
    endcase

    if (in_item_i.in_last) begin
      // a cut-off escape flushes what it holds, then the string ends
      unique case (mode_d)
        MODE_PCT: begin
          cmd.data_bytes[cmd.n_data] = CH_PCT;
          cmd.n_data  = cmd.n_data + 2'd1;
          cmd.has_end = 1'b1;
        end
        MODE_PCT1: begin
          cmd.data_bytes[cmd.n_data] = CH_PCT;
          cmd.n_data = cmd.n_data + 2'd1;
          cmd.data_bytes[cmd.n_data] = held_d;
          cmd.n_data  = cmd.n_data + 2'd1;
          cmd.has_end = 1'b1;
        end
        MODE_NORMAL: cmd.has_end = 1'b1;
        default: begin
        end
      endcase
      mode_d = MODE_NORMAL;
      held_d = '0;
    end
  end

  assign q_cmd_o  = cmd;
  assign q_push_o = accept && ((cmd.n_data != 2'd0) || cmd.has_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      held_q <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      held_q <= held_d;
    end
  end

endmodule

### rtl/ufpd_fifo.sv
module ufpd_fifo #(
  parameter int unsigned DEPTH = ufpd_pkg::Q_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ufpd_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ufpd_pkg::cmd_t head_o
);
  import ufpd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

### rtl/ufpd_back.sv
module ufpd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  ufpd_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ufpd_pkg::out_item_t out_item_o
);
  import ufpd_pkg::*;

  localparam logic [LEN_W-1:0] CAP = LEN_W'(LEN_CAP);

  logic [1:0]       idx_q;
  logic [LEN_W-1:0] count_q;
  logic             out_valid_q;
  out_item_t        out_q;
  logic             load;
  logic [2:0]       total;
  logic             final_one;
  logic             is_data;

  assign total     = {1'b0, cmd_i.n_data} + {2'b00, cmd_i.has_end};
  assign final_one = ({1'b0, idx_q} + 3'd1) == total;
  assign is_data   = idx_q < cmd_i.n_data;
  assign load      = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign cmd_pop_o = load && final_one;

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (is_data) begin
        out_q.out_kind   <= KIND_DATA;
        out_q.out_byte   <= cmd_i.data_bytes[idx_q];
        out_q.out_length <= '0;
      end else begin
        out_q.out_kind   <= KIND_END;
        out_q.out_byte   <= '0;
        out_q.out_length <= count_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= final_one ? 2'd0 : idx_q + 2'd1;
        if (!is_data) begin
          count_q <= '0;
        end else if (count_q < CAP) begin
          count_q <= count_q + LEN_W'(1);
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### rtl/url_form_percent_decoder.sv
// Form-encoded text decoder. One raw byte enters per item; in_last marks the
// final byte of a field. '+' becomes a space, %XY with two hex digits of
// either case becomes one byte, and a bad escape is passed through raw as
// '%' and its two characters. '&', '<', '>', newline or a zero byte ends the
// string with an end item carrying the decoded length (saturating at 2048);
// after that, bytes are dropped until the flagged byte. The front decoder turns
// each input item combinationally into a command of up to three data bytes
// plus an optional end marker; a command queue (two entries by default) feeds
// the back end, which emits one result item per cycle, while the output is not
// stalled, from a registered output stage. Sustained rate is one input item per
// cycle while each yields at most one result and the output is not stalled; an
// item that yields several results holds the back end until all are emitted,
// and the queue lets the front keep accepting during that time until it fills.
module url_form_percent_decoder #(
  parameter int unsigned QUEUE_DEPTH = ufpd_pkg::Q_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ufpd_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ufpd_pkg::out_item_t out_item_o
);
  import ufpd_pkg::*;

  // front to queue
  logic q_push, q_full;
  cmd_t q_wr_cmd;
  // queue to back end
  logic q_valid, q_pop;
  cmd_t q_head;

  // classification and escape state
  ufpd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_wr_cmd)
  );

  // decouples the two sides so either may stall alone
  ufpd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_wr_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  // serialises commands into items and keeps the length count
  ufpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_head),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

### rtl/ufpd_checker.sv
module ufpd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ufpd_pkg::out_item_t out_item_o
);
  import ufpd_pkg::*;

  // a stalled item stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item changed while stalled");

  a_end_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.out_kind == KIND_END) |-> out_item_o.out_byte == '0)
    else $error("end item with non-zero byte");

  a_data_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.out_kind == KIND_DATA) |-> out_item_o.out_length == '0)
    else $error("data item with non-zero length");

  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.out_length <= LEN_W'(LEN_CAP))
    else $error("length above saturation cap");

endmodule

bind url_form_percent_decoder ufpd_checker u_ufpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

### tb/tb_url_form_percent_decoder.sv
`timescale 1ns / 1ps

module tb_url_form_percent_decoder;
  import ufpd_pkg::*;

  // Decoder state as tracked by the model below.
  typedef enum logic [1:0] {
    MODE_TEXT,      // plain text
    MODE_PCT,       // '%' seen
    MODE_PCT_HELD,  // '%' and one character seen
    MODE_DONE       // string ended, dropping bytes up to the flagged one
  } dec_mode_e;

  // One row of the directed table. Where 'typed' is set the single result is
  // written out by hand; otherwise the decode model supplies the results.
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  localparam int DIR_ROWS = 29;
  localparam int LIVE_TARGET = 400;

  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{'{CH_NUL,   1'b0}, 1'b1, '{KIND_END,  8'h00,    12'd0}},  // zero ends at once
    '{'{"x",      1'b1}, 1'b0, '0},                             // dropped, flag clears
    '{'{8'hFF,    1'b0}, 1'b1, '{KIND_DATA, 8'hFF,    12'd0}},  // top byte passes
    '{'{CH_PLUS,  1'b0}, 1'b1, '{KIND_DATA, CH_SPACE, 12'd0}},  // plus to space
    '{'{CH_PCT,   1'b0}, 1'b0, '0},                             // %4a, lower case
    '{'{"4",      1'b0}, 1'b0, '0},
    '{'{"a",      1'b0}, 1'b0, '0},
    '{'{CH_PCT,   1'b0}, 1'b0, '0},                             // %00 is data
    '{'{"0",      1'b0}, 1'b0, '0},
    '{'{"0",      1'b0}, 1'b0, '0},
    '{'{CH_PCT,   1'b0}, 1'b0, '0},                             // %g1, bad escape
    '{'{"g",      1'b0}, 1'b0, '0},
    '{'{"1",      1'b0}, 1'b0, '0},
    '{'{CH_PCT,   1'b0}, 1'b0, '0},                             // '&' held, then zero
    '{'{CH_AMP,   1'b0}, 1'b0, '0},
    '{'{CH_NUL,   1'b0}, 1'b0, '0},
    '{'{CH_GT,    1'b1}, 1'b0, '0},                             // flag after the end
    '{'{CH_LT,    1'b0}, 1'b1, '{KIND_END,  8'h00,    12'd0}},
    '{'{"a",      1'b1}, 1'b0, '0},
    '{'{CH_PCT,   1'b0}, 1'b0, '0},                             // cut off after %B
    '{'{"B",      1'b1}, 1'b0, '0},
    '{'{CH_LF,    1'b1}, 1'b1, '{KIND_END,  8'h00,    12'd0}},
    '{'{CH_PCT,   1'b1}, 1'b0, '0},                             // cut off after %
    '{'{"q",      1'b0}, 1'b0, '0},
    '{'{CH_GT,    1'b1}, 1'b0, '0},                             // end on flagged byte
    '{'{CH_PCT,   1'b0}, 1'b0, '0},                             // zero after %
    '{'{CH_NUL,   1'b1}, 1'b0, '0},
    '{'{CH_AMP,   1'b1}, 1'b1, '{KIND_END,  8'h00,    12'd0}},
    '{'{"F",      1'b1}, 1'b0, '0}
  };

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      in_ready_o;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  // Model state.
  dec_mode_e        pred_mode  = MODE_TEXT;
  logic [7:0]       pred_held  = '0;
  logic [LEN_W-1:0] pred_count = '0;

  out_item_t step_q [$];     // results of the item just accepted
  out_item_t decoded_q [$];  // results still owed by the block, oldest first
  in_item_t  field_q [$];    // bytes of the field being sent

  int live_items = 0;  // items that reached the decoder while a string was open
  int fail_cnt   = 0;
  int next_gap   = 0;
  bit send_busy  = 1'b1;
  bit take_busy  = 1'b1;

  always #4 clk_i = ~clk_i;

  url_form_percent_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // ---------------------------------------------------------------------------
  // Decode model
  // ---------------------------------------------------------------------------

  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    return -1;
  endfunction

  function automatic bit ends_string(logic [7:0] c);
    return c == CH_AMP || c == CH_LT || c == CH_GT || c == CH_LF || c == CH_NUL;
  endfunction

  function automatic void emit_data(logic [7:0] b);
    step_q.push_back('{out_kind: KIND_DATA, out_byte: b, out_length: '0});
    // length saturates, data keeps flowing
    if (pred_count < LEN_CAP) pred_count++;
  endfunction

  function automatic void emit_end();
    step_q.push_back('{out_kind: KIND_END, out_byte: '0, out_length: pred_count});
    pred_mode = MODE_DONE;
  endfunction

  function automatic void predict_decode(in_item_t it);
    logic [7:0] b;
    int hi;
    int lo;
    b = it.in_byte;
    step_q.delete();
    if (pred_mode != MODE_DONE) live_items++;

    case (pred_mode)
      MODE_TEXT: begin
        if (b == CH_PLUS) emit_data(CH_SPACE);
        else if (b == CH_PCT) pred_mode = MODE_PCT;
        else if (ends_string(b)) emit_end();
        else emit_data(b);
      end
      MODE_PCT: begin
        // only a zero ends the string inside an escape
        if (b == CH_NUL) begin
          emit_data(CH_PCT);
          emit_end();
        end else begin
          pred_held = b;
          pred_mode = MODE_PCT_HELD;
        end
      end
      MODE_PCT_HELD: begin
        hi = hex_digit(pred_held);
        lo = hex_digit(b);
        pred_mode = MODE_TEXT;
        if (hi >= 0 && lo >= 0) begin
          emit_data(8'(hi * 16 + lo));
        end else begin
          // bad escape goes out raw, up to a zero
          emit_data(CH_PCT);
          emit_data(pred_held);
          if (b == CH_NUL) emit_end();
          else emit_data(b);
        end
        pred_held = '0;
      end
      default: ;
    endcase

    if (it.in_last) begin
      // a cut-off escape flushes what it holds, then the string ends
      case (pred_mode)
        MODE_PCT: begin
          emit_data(CH_PCT);
          emit_end();
        end
        MODE_PCT_HELD: begin
          emit_data(CH_PCT);
          emit_data(pred_held);
          emit_end();
        end
        MODE_TEXT: emit_end();
        default: ;
      endcase
      pred_mode  = MODE_TEXT;
      pred_held  = '0;
      pred_count = '0;
    end else if (pred_mode == MODE_DONE) begin
      pred_count = '0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sending side
  // ---------------------------------------------------------------------------

  // Drives one item and books its results once the block takes it. Valid is
  // lowered only when a gap follows, so back-to-back items keep it high.
  task automatic send_item(in_item_t it, logic typed, out_item_t want);
    repeat (next_gap) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predict_decode(it);
    if (typed) decoded_q.push_back(want);
    else while (step_q.size() != 0) decoded_q.push_back(step_q.pop_front());
    if ($urandom_range(0, 39) == 0) send_busy = !send_busy;
    next_gap = send_busy ? $urandom_range(0, 17) : 0;
    if (next_gap != 0) in_valid_i <= 1'b0;
  endtask

  // Holds the sender off until every booked result has come out.
  task automatic wait_drained();
    if (next_gap == 0) in_valid_i <= 1'b0;
    do @(posedge clk_i); while (decoded_q.size() != 0);
  endtask

  function automatic void push_byte(logic [7:0] b, logic last);
    field_q.push_back('{in_byte: b, in_last: last});
  endfunction

  // Any byte with no special meaning in plain text.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == CH_PCT || c == CH_PLUS || c == CH_AMP || c == CH_LT ||
           c == CH_GT || c == CH_LF);
    return c;
  endfunction

  function automatic logic [7:0] rand_hex();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(48 + v);
    return $urandom_range(0, 1) ? 8'(55 + v) : 8'(87 + v);
  endfunction

  function automatic logic [7:0] rand_term();
    case ($urandom_range(0, 4))
      0: return CH_AMP;
      1: return CH_LT;
      2: return CH_GT;
      3: return CH_LF;
      default: return CH_NUL;
    endcase
  endfunction

  // Mostly well-formed fields of random tokens; some raw noise with random
  // flags, which also leaves escapes open across field boundaries.
  function automatic void build_field();
    int n;
    logic [7:0] c1;
    logic [7:0] c2;
    in_item_t tail;
    if ($urandom_range(0, 99) < 12) begin
      n = $urandom_range(1, 8);
      repeat (n) push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      return;
    end
    n = $urandom_range(0, 7);
    repeat (n) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: push_byte(plain_char(), 1'b0);
        7, 8:  push_byte(CH_PLUS, 1'b0);
        9, 10, 11, 12, 13: begin
          push_byte(CH_PCT, 1'b0);
          push_byte(rand_hex(), 1'b0);
          push_byte(rand_hex(), 1'b0);
        end
        14, 15, 16: begin
          c1 = 8'($urandom_range(1, 255));
          c2 = ($urandom_range(0, 7) == 0) ? CH_NUL : 8'($urandom_range(0, 255));
          if (hex_digit(c1) >= 0 && hex_digit(c2) >= 0) c2 = "g";
          push_byte(CH_PCT, 1'b0);
          push_byte(c1, 1'b0);
          push_byte(c2, 1'b0);
        end
        17: begin
          push_byte(CH_PCT, 1'b0);
          push_byte("0", 1'b0);
          push_byte("0", 1'b0);
        end
        default: push_byte(rand_term(), 1'b0);
      endcase
    end
    case ($urandom_range(0, 9))
      0: push_byte(CH_PCT, 1'b1);
      1: begin
        push_byte(CH_PCT, 1'b0);
        push_byte(8'($urandom_range(1, 255)), 1'b1);
      end
      default: begin
        if (field_q.size() == 0) begin
          push_byte(plain_char(), 1'b1);
        end else begin
          tail = field_q.pop_back();
          tail.in_last = 1'b1;
          field_q.push_back(tail);
        end
      end
    endcase
  endfunction

  task automatic send_field();
    in_item_t it;
    while (field_q.size() != 0) begin
      it = field_q.pop_front();
      send_item(it, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiving side
  // ---------------------------------------------------------------------------

  function automatic void check_result(out_item_t got);
    out_item_t want;
    if (decoded_q.size() == 0) begin
      $display("%0t: unexpected item kind %0d byte %02h length %0d", $time,
               got.out_kind, got.out_byte, got.out_length);
      fail_cnt++;
      return;
    end
    want = decoded_q.pop_front();
    if (got.out_kind !== want.out_kind) begin
      $display("%0t: out_kind expected %0d got %0d", $time, want.out_kind, got.out_kind);
      fail_cnt++;
    end
    if (got.out_byte !== want.out_byte) begin
      $display("%0t: out_byte expected %02h got %02h", $time, want.out_byte, got.out_byte);
      fail_cnt++;
    end
    if (got.out_length !== want.out_length) begin
      $display("%0t: out_length expected %0d got %0d", $time, want.out_length,
               got.out_length);
      fail_cnt++;
    end
  endfunction

  // Ready drops for a random stall before each item, with spells of none.
  initial begin
    int stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = take_busy ? $urandom_range(0, 17) : 0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      check_result(out_item_o);
      if ($urandom_range(0, 39) == 0) take_busy = !take_busy;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int fields;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_item(DIR_TAB[i].item, DIR_TAB[i].typed, DIR_TAB[i].want);
    end

    fields = 0;
    while (live_items < LIVE_TARGET) begin
      build_field();
      send_field();
      fields++;
      // let the block run dry now and then, once for certain
      if (fields == 6 || $urandom_range(0, 14) == 0) wait_drained();
    end

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

### sim.f
rtl/ufpd_pkg.sv
rtl/ufpd_front.sv
rtl/ufpd_fifo.sv
rtl/ufpd_back.sv
rtl/url_form_percent_decoder.sv
rtl/ufpd_checker.sv
tb/tb_url_form_percent_decoder.sv
